// ===== hdl/eabs_pkg.sv =====
// Shared types, constants and the reciprocal table for the 3x3 box smoothing block.
package eabs_pkg;

    localparam int CFG_W     = 11;
    localparam int ROW_W     = 11;
    localparam int MAX_ROWS  = 1024;
    localparam int DATA_W    = 16;
    localparam int SUM3_W    = 18;
    localparam int SUM9_W    = 20;
    localparam int CNT3_W    = 2;
    localparam int CNT9_W    = 4;
    localparam int MAG_W     = 19;
    localparam int NUM_W     = 20;
    localparam int RCP_W     = 26;
    localparam int RCP_SHIFT = 26;
    localparam int PROD_W    = NUM_W + RCP_W;
    localparam int QUO_W     = 17;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;

    // Per-beat control from the front end to the datapath
    typedef struct packed {
        logic top_ok;
        logic mid_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic wr;
        logic emit;
        logic last;
    } eabs_evt_t;

    localparam int EVT_W = $bits(eabs_evt_t);

    // ceil(2^26 / (2*n)): floor((2*mag+n)/(2n)) == (num * rcp) >> 26 for num < 2^21
    function automatic logic [RCP_W-1:0] recip(input logic [CNT9_W-1:0] n);
        logic [RCP_W-1:0] r;
        case (n)
            4'd1:    r = 26'd33554432;
            4'd2:    r = 26'd16777216;
            4'd3:    r = 26'd11184811;
            4'd4:    r = 26'd8388608;
            4'd5:    r = 26'd6710887;
            4'd6:    r = 26'd5592406;
            4'd7:    r = 26'd4793491;
            4'd8:    r = 26'd4194304;
            4'd9:    r = 26'd3728271;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/eabs_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
module eabs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/eabs_front.sv =====
// Front end: config registers, raster counters and per-beat classification.
module eabs_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [eabs_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_opcode,
    input  logic [eabs_pkg::DATA_W-1:0]   s_height,
    input  logic                          q_ready,
    output logic                          push,
    output eabs_pkg::eabs_evt_t           push_evt,
    output logic [$clog2(MAX_WIDTH)-1:0]  push_col,
    output logic [eabs_pkg::DATA_W-1:0]   push_data
);
    import eabs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > CFG_W) ? WW : CFG_W;
    localparam int WIDTH_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;

    logic [WW-1:0]    width_reg, width_next;
    logic [ROW_W-1:0] height_reg, height_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             full_reg, full_next;
    logic [WW-1:0]    dcol_reg, dcol_next;
    logic             dud_reg, dud_next;

    logic          s_acc;
    logic          w_ge2, h_ge2, col_last, row_last, dcol_end;
    logic [CW-1:0] k;

    assign s_tready = q_ready && !dud_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign w_ge2    = width_reg >= WW'(2);
    assign h_ge2    = height_reg >= ROW_W'(2);
    assign col_last = WW'(col_reg) == width_reg - WW'(1);
    assign row_last = row_reg == height_reg - ROW_W'(1);
    assign dcol_end = dcol_reg == width_reg;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        full_next   = full_reg;
        dcol_next   = dcol_reg;
        dud_next    = dud_reg;
        push        = 1'b0;
        push_evt    = '0;
        push_col    = '0;
        push_data   = s_height;
        k           = dcol_end ? '0 : dcol_reg[CW-1:0];

        if (cfg_we) begin
            case (cfg_addr)
                REG_MAP_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        width_next = WW'(1);
                    end else if (XW'(cfg_wdata) > XW'(MAX_WIDTH)) begin
                        width_next = WW'(MAX_WIDTH);
                    end else begin
                        width_next = WW'(cfg_wdata);
                    end
                end
                REG_MAP_HEIGHT: begin
                    if (cfg_wdata == '0) begin
                        height_next = ROW_W'(1);
                    end else if (cfg_wdata > CFG_W'(MAX_ROWS)) begin
                        height_next = ROW_W'(MAX_ROWS);
                    end else begin
                        height_next = cfg_wdata;
                    end
                end
                default: begin
                end
            endcase
            col_next  = '0;
            row_next  = '0;
            full_next = 1'b0;
            dcol_next = '0;
            dud_next  = 1'b0;
        end else if (dud_reg && q_ready) begin
            // one-row map: prime the window with the first phantom column, no result
            push              = 1'b1;
            push_evt.mid_ok   = 1'b1;
            push_evt.left_ok  = w_ge2;
            dcol_next         = WW'(1);
            dud_next          = 1'b0;
        end else if (s_acc) begin
            if (!full_reg) begin
                if (s_opcode == OP_SAMPLE) begin
                    push              = 1'b1;
                    push_col          = col_reg;
                    push_evt.top_ok   = row_reg >= ROW_W'(2);
                    push_evt.mid_ok   = row_reg != '0;
                    push_evt.bot_ok   = 1'b1;
                    push_evt.left_ok  = (col_reg >= CW'(2)) || (col_reg == '0 && w_ge2);
                    push_evt.right_ok = col_reg != '0;
                    push_evt.wr       = 1'b1;
                    push_evt.emit     = (row_reg >= ROW_W'(2)) ||
                                        (row_reg == ROW_W'(1) && col_reg != '0);
                    if (col_last) begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                        if (row_last) begin
                            full_next = 1'b1;
                            dcol_next = '0;
                            dud_next  = !h_ge2;
                        end
                    end else begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end else begin
                // drain: phantom row below the map, then one closing beat
                push              = 1'b1;
                push_col          = k;
                push_evt.top_ok   = h_ge2;
                push_evt.mid_ok   = 1'b1;
                push_evt.left_ok  = (k >= CW'(2)) || (k == '0 && w_ge2);
                push_evt.right_ok = (dcol_reg != '0) && !dcol_end;
                push_evt.emit     = 1'b1;
                push_evt.last     = dcol_end;
                if (dcol_end) begin
                    col_next  = '0;
                    row_next  = '0;
                    full_next = 1'b0;
                    dcol_next = '0;
                end else begin
                    dcol_next = dcol_reg + WW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(WIDTH_RST);
            height_reg <= ROW_W'(256);
            col_reg    <= '0;
            row_reg    <= '0;
            full_reg   <= 1'b0;
            dcol_reg   <= '0;
            dud_reg    <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            full_reg   <= full_next;
            dcol_reg   <= dcol_next;
            dud_reg    <= dud_next;
        end
    end

endmodule

// ===== hdl/eabs_queue.sv =====
// Four-entry FIFO between the front end and the datapath.
module eabs_queue #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    import eabs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;

    assign ready = count_reg != (PW + 1)'(DEPTH);
    assign empty = count_reg == '0;
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (PW + 1)'(1);
            2'b01:   count_next = count_reg - (PW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/eabs_back.sv =====
// Datapath: line buffers, column sums, 3x3 window and rounded divide by cell count.
module eabs_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           q_empty,
    input  logic [eabs_pkg::EVT_W+$clog2(MAX_WIDTH)+eabs_pkg::DATA_W-1:0] q_dout,
    output logic                                           pop,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    output logic [eabs_pkg::DATA_W-1:0]                    m_height,
    output logic                                           m_last
);
    import eabs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic adv;

    eabs_evt_t               h_evt;
    logic [CW-1:0]           h_col;
    logic [DATA_W-1:0]       h_data;

    // read stage
    logic                    b_vld_reg;
    eabs_evt_t               b_evt_reg;
    logic [CW-1:0]           b_col_reg;
    logic signed [DATA_W-1:0] b_data_reg;
    logic                    fwd_reg;
    logic [DATA_W-1:0]       fwd1_reg, fwd2_reg;
    logic [DATA_W-1:0]       rd1, rd2;
    logic signed [DATA_W-1:0] lb1, lb2;
    logic                    b_we;

    // window
    logic signed [SUM3_W-1:0] a_sum_reg, b_sum_reg, n_sum;
    logic [CNT3_W-1:0]        a_cnt_reg, b_cnt_reg, n_cnt;
    logic signed [DATA_W-1:0] top_v, mid_v, bot_v;
    logic signed [SUM3_W-1:0] left_s, right_s;
    logic [CNT9_W-1:0]        left_c, right_c;
    logic signed [SUM9_W-1:0] win_sum;
    logic [CNT9_W-1:0]        win_cnt;

    // divide stages
    logic                     c_vld_reg, c_last_reg;
    logic signed [SUM9_W-1:0] c_sum_reg;
    logic [CNT9_W-1:0]        c_cnt_reg;
    logic                     x_vld_reg, x_last_reg, x_neg_reg;
    logic [NUM_W-1:0]         x_num_reg, x_num_next;
    logic [RCP_W-1:0]         x_rcp_reg;
    logic [MAG_W-1:0]         mag;
    logic                     p_vld_reg, p_last_reg, p_neg_reg;
    logic [PROD_W-1:0]        p_prod_reg;
    logic [QUO_W-1:0]         quo, res;
    logic                     m_tvalid_reg, m_last_reg;
    logic [DATA_W-1:0]        m_height_reg;

    assign adv = !m_tvalid_reg || m_tready;
    assign pop = adv && !q_empty;
    assign {h_evt, h_col, h_data} = q_dout;

    assign b_we = adv && b_vld_reg && b_evt_reg.wr;
    assign lb1  = fwd_reg ? fwd1_reg : rd1;
    assign lb2  = fwd_reg ? fwd2_reg : rd2;

    eabs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_row_above (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_col_reg),
        .wdata (b_data_reg),
        .re    (pop),
        .raddr (h_col),
        .rdata (rd1)
    );

    eabs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_row_two_above (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_col_reg),
        .wdata (lb1),
        .re    (pop),
        .raddr (h_col),
        .rdata (rd2)
    );

    always_comb begin
        top_v   = b_evt_reg.top_ok ? lb2 : '0;
        mid_v   = b_evt_reg.mid_ok ? lb1 : '0;
        bot_v   = b_evt_reg.bot_ok ? b_data_reg : '0;
        n_sum   = SUM3_W'(top_v) + SUM3_W'(mid_v) + SUM3_W'(bot_v);
        n_cnt   = CNT3_W'(b_evt_reg.top_ok) + CNT3_W'(b_evt_reg.mid_ok) +
                  CNT3_W'(b_evt_reg.bot_ok);
        left_s  = b_evt_reg.left_ok ? a_sum_reg : '0;
        left_c  = b_evt_reg.left_ok ? CNT9_W'(a_cnt_reg) : '0;
        right_s = b_evt_reg.right_ok ? n_sum : '0;
        right_c = b_evt_reg.right_ok ? CNT9_W'(n_cnt) : '0;
        win_sum = SUM9_W'(left_s) + SUM9_W'(b_sum_reg) + SUM9_W'(right_s);
        win_cnt = left_c + CNT9_W'(b_cnt_reg) + right_c;
    end

    always_comb begin
        mag        = c_sum_reg[SUM9_W-1] ? MAG_W'(-c_sum_reg) : MAG_W'(c_sum_reg);
        x_num_next = {mag, 1'b0} + NUM_W'(c_cnt_reg);
        quo        = p_prod_reg[RCP_SHIFT +: QUO_W];
        res        = p_neg_reg ? -quo : quo;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_evt_reg  <= h_evt;
            b_col_reg  <= h_col;
            b_data_reg <= h_data;
            // hold what the beat ahead writes when it hits the same column
            fwd_reg    <= pop && b_we && (h_col == b_col_reg);
            fwd1_reg   <= b_data_reg;
            fwd2_reg   <= lb1;
            if (b_vld_reg) begin
                a_sum_reg <= b_sum_reg;
                a_cnt_reg <= b_cnt_reg;
                b_sum_reg <= n_sum;
                b_cnt_reg <= n_cnt;
            end
            c_last_reg   <= b_evt_reg.last;
            c_sum_reg    <= win_sum;
            c_cnt_reg    <= win_cnt;
            x_last_reg   <= c_last_reg;
            x_neg_reg    <= c_sum_reg[SUM9_W-1];
            x_num_reg    <= x_num_next;
            x_rcp_reg    <= recip(c_cnt_reg);
            p_last_reg   <= x_last_reg;
            p_neg_reg    <= x_neg_reg;
            p_prod_reg   <= PROD_W'(x_num_reg) * PROD_W'(x_rcp_reg);
            m_last_reg   <= p_last_reg;
            m_height_reg <= res[DATA_W-1:0];
        end
        if (!aresetn) begin
            b_vld_reg    <= 1'b0;
            c_vld_reg    <= 1'b0;
            x_vld_reg    <= 1'b0;
            p_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg    <= pop;
            c_vld_reg    <= b_vld_reg && b_evt_reg.emit;
            x_vld_reg    <= c_vld_reg;
            p_vld_reg    <= x_vld_reg;
            m_tvalid_reg <= p_vld_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_height = m_height_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== hdl/edge_aware_box_smoothing_3x3.sv =====
// A result is registered in the c, x, p and m stages after its 3x3 window completes.
// Throughput: one beat per cycle while the output is not stalled; the line buffers
// take one read and one write a cycle; a one-row map adds a priming beat per frame.
// Output lags input by one row plus one cell; flush beats drain the last row plus one
// (a map one row tall drains just its row).
// Reset clears the counters and pipeline, sets height to 256 and width to the
// smaller of 256 and MAX_WIDTH; the line buffers are not cleared.
module edge_aware_box_smoothing_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [eabs_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] height_in
    input  logic                        s_tuser,   // [0] opcode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [15:0] height_out
    output logic                        m_tlast
);
    import eabs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = EVT_W + CW + DATA_W;

    logic              push, q_ready, q_empty, pop;
    eabs_evt_t         push_evt;
    logic [CW-1:0]     push_col;
    logic [DATA_W-1:0] push_data;
    logic [QW-1:0]     q_dout;

    eabs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_opcode  (s_tuser),
        .s_height  (s_tdata),
        .q_ready   (q_ready),
        .push      (push),
        .push_evt  (push_evt),
        .push_col  (push_col),
        .push_data (push_data)
    );

    eabs_queue #(.WIDTH(QW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     ({push_evt, push_col, push_data}),
        .ready   (q_ready),
        .pop     (pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    eabs_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_dout   (q_dout),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_height (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the streaming 3x3 box mean over a height map.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import eabs_pkg::*;

    localparam logic OP_FLUSH = ~OP_SAMPLE;
    localparam int   HIST_DEPTH = 2 * 1024 + 4;
    localparam int   IDLE_LIMIT = 5000;
    localparam int   SETTLE = 12;

    typedef struct {
        logic [15:0] height;
        logic        last;
    } smooth_cell_t;

    class smoothing_scoreboard;
        int           heights[HIST_DEPTH];
        logic [10:0]  width_reg = 11'd256;
        logic [10:0]  height_reg = 11'd256;
        int           in_col, in_row, out_pos;
        smooth_cell_t cells_due[$];
        int           errors;

        function int clamp_dim(int v, int hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_pos = 0;
        endfunction

        function void configure(logic idx, logic [10:0] val);
            if (idx == REG_MAP_WIDTH) width_reg = val;
            else height_reg = val;
            restart();
        endfunction

        function bit busy();
            return (in_col != 0) || (in_row != 0) || (out_pos != 0);
        endfunction

        // Advance the map position for one accepted beat and queue the mean it releases.
        function void note_input(logic op, logic [15:0] data);
            int w, h, total, count, r, c, sum, n, mag, q, rr, cc;
            bit took;
            smooth_cell_t item;
            w = clamp_dim(width_reg, 1024);
            h = clamp_dim(height_reg, MAX_ROWS);
            total = w * h;
            count = in_row * w + in_col;
            took = 0;
            if (op == OP_SAMPLE && count < total) begin
                heights[count % HIST_DEPTH] = int'($signed(data));
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
                count++;
                took = 1;
            end
            if (out_pos >= total) begin
                restart();
                return;
            end
            if (took ? (count < out_pos + w + 2) : (count != total)) return;
            r = out_pos / w;
            c = out_pos % w;
            sum = 0;
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
                rr = r + dr;
                if (rr < 0 || rr >= h) continue;
                for (int dc = -1; dc <= 1; dc++) begin
                    cc = c + dc;
                    if (cc < 0 || cc >= w) continue;
                    sum += heights[(rr * w + cc) % HIST_DEPTH];
                    n++;
                end
            end
            // round half away from zero
            mag = (sum < 0) ? -sum : sum;
            q = (2 * mag + n) / (2 * n);
            item.height = 16'((sum < 0) ? -q : q);
            item.last = (out_pos == total - 1);
            out_pos++;
            if (item.last) restart();
            cells_due.push_back(item);
        endfunction

        function void check_result(logic [15:0] height, logic last);
            smooth_cell_t want;
            if (cells_due.size() == 0) begin
                $display("%0t: unexpected beat height=%h last=%b", $time, height, last);
                errors++;
                return;
            end
            want = cells_due.pop_front();
            if (height !== want.height) begin
                $display("%0t: height mismatch expected %h actual %h",
                         $time, want.height, height);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_addr = 0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    smoothing_scoreboard sb = new();
    int  beats_sent;
    int  burst_left;
    bit  gaps_on = 1;
    bit  long_hold_req;
    int  idle_cycles;

    always #4 aclk = ~aclk;

    edge_aware_box_smoothing_3x3 DUT (.*);

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: stall patterns change at random; long hold-off when requested.
    initial begin
        int mode, hold;
        mode = 0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold = 400;
            end
            if ($urandom_range(63) == 0) mode = $urandom_range(3);
            if (hold > 0) begin
                hold--;
                m_tready = 0;
            end else begin
                case (mode)
                    0: m_tready = 1;
                    1: m_tready = ($urandom_range(3) != 0);
                    2: m_tready = 1'($urandom_range(1));
                    default: m_tready = ($urandom_range(7) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(logic op, logic [15:0] data);
        @(negedge aclk);
        s_tvalid = 1;
        s_tuser = op;
        s_tdata = data;
        do @(posedge aclk); while (!s_tready);
        // let the monitor note the beat before the caller looks at the scoreboard
        #1;
        beats_sent++;
        if (burst_left > 0) burst_left--;
        else if (gaps_on) begin
            burst_left = $urandom_range(30);
            @(negedge aclk);
            s_tvalid = 0;
            if ($urandom_range(40) == 0) begin
                // hold until every result has drained
                while (sb.cells_due.size() != 0) @(posedge aclk);
            end else begin
                repeat ($urandom_range(6)) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 0;
        while (sb.cells_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        @(negedge aclk);
        cfg_we = 1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.configure(idx, val);
        @(negedge aclk);
        cfg_we = 0;
    endtask

    // fill: 0 random, 1 all max, 2 all min, 3 ramp
    task automatic play_map(logic [10:0] w_raw, logic [10:0] h_raw, int fill, bit noisy);
        int total, cut;
        logic [15:0] v;
        wait_idle();
        write_reg(REG_MAP_WIDTH, w_raw);
        write_reg(REG_MAP_HEIGHT, h_raw);
        total = sb.clamp_dim(w_raw, 1024) * sb.clamp_dim(h_raw, MAX_ROWS);
        cut = (noisy && $urandom_range(9) == 0) ? $urandom_range(total) : -1;
        for (int i = 0; i < total; i++) begin
            if (i == cut) return;
            if (noisy && $urandom_range(15) == 0) send_beat(OP_FLUSH, 16'($urandom));
            case (fill)
                1: v = 16'h7fff;
                2: v = 16'h8000;
                3: v = 16'(i + 1);
                default: v = 16'($urandom);
            endcase
            send_beat(OP_SAMPLE, v);
        end
        // drain; a sample past the full map acts as a flush
        while (sb.busy()) begin
            if (noisy && $urandom_range(7) == 0) send_beat(OP_SAMPLE, 16'($urandom));
            else send_beat(OP_FLUSH, 16'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1;

        play_map(11'd3, 11'd3, 1, 0);
        play_map(11'd3, 11'd3, 2, 0);
        play_map(11'd0, 11'd0, 0, 0);
        play_map(11'd2, 11'd1, 3, 1);
        play_map(11'd4, 11'd3, 0, 1);
        long_hold_req = 1;
        play_map(11'd6, 11'd5, 0, 0);
        play_map(11'd1, 11'd2047, 0, 0);

        while (beats_sent < 1450) begin
            gaps_on = ($urandom_range(3) != 0);
            if ($urandom_range(19) == 0)
                play_map(11'($urandom_range(1, 40)), 11'($urandom_range(0, 2)), 0, 1);
            else
                play_map(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)), 0, 1);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.cells_due.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
